>>> rtl/core/lpqm_pkg.sv
package lpqm_pkg;

	// operation codes
	localparam logic [2:0] OP_ALLOC    = 3'd0;
	localparam logic [2:0] OP_MAKE_RUN = 3'd1;
	localparam logic [2:0] OP_SCHEDULE = 3'd2;
	localparam logic [2:0] OP_SLEEP    = 3'd3;
	localparam logic [2:0] OP_WAKEUP   = 3'd4;
	localparam logic [2:0] OP_EXIT     = 3'd5;
	localparam logic [2:0] OP_FREE     = 3'd6;
	localparam logic [2:0] OP_KILL     = 3'd7;

	// result status codes
	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_EMPTY   = 2'd1;
	localparam logic [1:0] RES_MISSING = 2'd2;

	// entry status codes
	localparam logic [2:0] STAT_UNUSED   = 3'd0;
	localparam logic [2:0] STAT_USED     = 3'd1;
	localparam logic [2:0] STAT_SLEEPING = 3'd2;
	localparam logic [2:0] STAT_RUNNABLE = 3'd3;
	localparam logic [2:0] STAT_RUNNING  = 3'd4;
	localparam logic [2:0] STAT_ZOMBIE   = 3'd5;

	// head register slots, run lists follow from HD_RUN0
	localparam int HD_FREE   = 0;
	localparam int HD_SLEEP  = 1;
	localparam int HD_ZOMBIE = 2;
	localparam int HD_RUN0   = 3;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  entry_index;
		logic [2:0]  cpu_index;
		logic [15:0] channel;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] entry_out;
		logic [6:0] woken_count;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_KILL_CHK,
		S_RM_BEG, S_RM_CMP, S_RM_NXT, S_RM_CLR, S_RM_END,
		S_MV_RD, S_MV_SEL,
		S_AP_INIT, S_AP_RD, S_AP_CHK, S_AP_LINK, S_AP_CLR,
		S_WK_BEG, S_WK_RD, S_WK_CHK, S_WK_HRD, S_WK_HGET,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		C_NOP, C_CLEAR, C_LOAD, C_DECODE, C_KILL_CHK,
		C_RM_BEG, C_RM_CMP, C_RM_NXT, C_RM_CLR, C_RM_END,
		C_MV_RD, C_MV_SEL,
		C_AP_INIT, C_AP_RD, C_AP_CHK, C_AP_LINK, C_AP_CLR,
		C_WK_BEG, C_WK_RD, C_WK_CHK, C_WK_HRD, C_WK_HGET
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       bad;
		logic       clear_last;
		logic       head_entry;
		logic       cmp_ok;
		logic       cur_eq_t;
		logic       res_ok;
		logic       ap_more;
		logic       stat_sleep;
		logic       wk_go;
		logic       wk_stop;
		logic       k_lt_n;
	} flags_t;

	// ops that act on the entry_index field
	function automatic logic needs_entry(input logic [2:0] op);
		return !(op == OP_ALLOC || op == OP_SCHEDULE || op == OP_WAKEUP);
	endfunction

endpackage

>>> rtl/core/linked_process_queue_manager_core.sv
// channel   dir  signals                 beat
// request   in   start, busy, request    start high while busy low
// result    out  done, result            done high, one cycle, no backpressure
//
// appends and removals walk the target list through the link table.
// wakeup walks the sleeping list, then per hit runs a removal and, when
// that succeeds, an append. after reset a clearing pass over every entry
// fills the tables; busy stays high until it ends. the result stays valid
// from its one done cycle until the next request is taken.
module linked_process_queue_manager_core #(
	parameter int ENTRY_COUNT  = 64,
	parameter int CPU_COUNT    = 8,
	parameter int CHANNEL_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lpqm_pkg::req_t request,
	output logic           done,
	output lpqm_pkg::rsp_t result
);

	lpqm_pkg::cmd_t   cmd;
	lpqm_pkg::flags_t flags;

	// sequencer
	lpqm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// tables and list registers
	lpqm_datapath #(
		.ENTRY_COUNT  (ENTRY_COUNT),
		.CPU_COUNT    (CPU_COUNT),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.flags   (flags),
		.result  (result)
	);

endmodule

>>> rtl/core/lpqm_ctrl.sv
module lpqm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lpqm_pkg::flags_t flags,
	output lpqm_pkg::cmd_t   cmd,
	output logic             busy,
	output logic             done
);

	lpqm_pkg::state_t state_q, state_d, cont;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpqm_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// where a finished append returns to
	assign cont = (flags.op == lpqm_pkg::OP_WAKEUP) ? lpqm_pkg::S_WK_HRD : lpqm_pkg::S_DONE;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpqm_pkg::S_CLEAR: begin
				if (flags.clear_last) state_d = lpqm_pkg::S_IDLE;
			end
			lpqm_pkg::S_IDLE: begin
				if (start) state_d = lpqm_pkg::S_DECODE;
			end
			lpqm_pkg::S_DECODE: begin
				if (lpqm_pkg::needs_entry(flags.op) && flags.bad) begin
					state_d = lpqm_pkg::S_DONE;
				end else begin
					case (flags.op)
						lpqm_pkg::OP_ALLOC, lpqm_pkg::OP_SCHEDULE, lpqm_pkg::OP_FREE: begin
							state_d = lpqm_pkg::S_RM_BEG;
						end
						lpqm_pkg::OP_MAKE_RUN: state_d = lpqm_pkg::S_MV_RD;
						lpqm_pkg::OP_SLEEP, lpqm_pkg::OP_EXIT: state_d = lpqm_pkg::S_AP_INIT;
						lpqm_pkg::OP_KILL: state_d = lpqm_pkg::S_KILL_CHK;
						default: state_d = lpqm_pkg::S_WK_BEG;
					endcase
				end
			end
			lpqm_pkg::S_KILL_CHK: begin
				state_d = flags.stat_sleep ? lpqm_pkg::S_RM_BEG : lpqm_pkg::S_DONE;
			end
			lpqm_pkg::S_RM_BEG: begin
				state_d = flags.head_entry ? lpqm_pkg::S_RM_CMP : lpqm_pkg::S_RM_END;
			end
			lpqm_pkg::S_RM_CMP: begin
				state_d = flags.cmp_ok ? lpqm_pkg::S_RM_NXT : lpqm_pkg::S_RM_END;
			end
			lpqm_pkg::S_RM_NXT: begin
				state_d = flags.cur_eq_t ? lpqm_pkg::S_RM_CLR : lpqm_pkg::S_RM_CMP;
			end
			lpqm_pkg::S_RM_CLR: state_d = lpqm_pkg::S_RM_END;
			lpqm_pkg::S_RM_END: begin
				if (flags.op == lpqm_pkg::OP_WAKEUP) begin
					state_d = flags.res_ok ? lpqm_pkg::S_MV_RD : lpqm_pkg::S_WK_HRD;
				end else if (!flags.res_ok) begin
					state_d = lpqm_pkg::S_DONE;
				end else begin
					case (flags.op)
						lpqm_pkg::OP_FREE: state_d = lpqm_pkg::S_AP_INIT;
						lpqm_pkg::OP_KILL: state_d = lpqm_pkg::S_MV_RD;
						default: state_d = lpqm_pkg::S_DONE;
					endcase
				end
			end
			lpqm_pkg::S_MV_RD: state_d = lpqm_pkg::S_MV_SEL;
			lpqm_pkg::S_MV_SEL: state_d = lpqm_pkg::S_AP_INIT;
			lpqm_pkg::S_AP_INIT: begin
				state_d = flags.head_entry ? lpqm_pkg::S_AP_RD : cont;
			end
			lpqm_pkg::S_AP_RD: state_d = lpqm_pkg::S_AP_CHK;
			lpqm_pkg::S_AP_CHK: begin
				state_d = flags.ap_more ? lpqm_pkg::S_AP_RD : lpqm_pkg::S_AP_LINK;
			end
			lpqm_pkg::S_AP_LINK: state_d = lpqm_pkg::S_AP_CLR;
			lpqm_pkg::S_AP_CLR: state_d = cont;
			lpqm_pkg::S_WK_BEG: state_d = lpqm_pkg::S_WK_RD;
			lpqm_pkg::S_WK_RD: begin
				state_d = flags.wk_go ? lpqm_pkg::S_WK_CHK : lpqm_pkg::S_WK_HRD;
			end
			lpqm_pkg::S_WK_CHK: begin
				state_d = flags.wk_stop ? lpqm_pkg::S_WK_HRD : lpqm_pkg::S_WK_RD;
			end
			lpqm_pkg::S_WK_HRD: begin
				state_d = flags.k_lt_n ? lpqm_pkg::S_WK_HGET : lpqm_pkg::S_DONE;
			end
			lpqm_pkg::S_WK_HGET: state_d = lpqm_pkg::S_RM_BEG;
			lpqm_pkg::S_DONE: state_d = lpqm_pkg::S_IDLE;
			default: state_d = lpqm_pkg::S_IDLE;
		endcase
	end

	// datapath command per state
	always_comb begin
		busy = (state_q != lpqm_pkg::S_IDLE);
		done = (state_q == lpqm_pkg::S_DONE);
		case (state_q)
			lpqm_pkg::S_CLEAR:    cmd = lpqm_pkg::C_CLEAR;
			lpqm_pkg::S_IDLE:     cmd = start ? lpqm_pkg::C_LOAD : lpqm_pkg::C_NOP;
			lpqm_pkg::S_DECODE:   cmd = lpqm_pkg::C_DECODE;
			lpqm_pkg::S_KILL_CHK: cmd = lpqm_pkg::C_KILL_CHK;
			lpqm_pkg::S_RM_BEG:   cmd = lpqm_pkg::C_RM_BEG;
			lpqm_pkg::S_RM_CMP:   cmd = lpqm_pkg::C_RM_CMP;
			lpqm_pkg::S_RM_NXT:   cmd = lpqm_pkg::C_RM_NXT;
			lpqm_pkg::S_RM_CLR:   cmd = lpqm_pkg::C_RM_CLR;
			lpqm_pkg::S_RM_END:   cmd = lpqm_pkg::C_RM_END;
			lpqm_pkg::S_MV_RD:    cmd = lpqm_pkg::C_MV_RD;
			lpqm_pkg::S_MV_SEL:   cmd = lpqm_pkg::C_MV_SEL;
			lpqm_pkg::S_AP_INIT:  cmd = lpqm_pkg::C_AP_INIT;
			lpqm_pkg::S_AP_RD:    cmd = lpqm_pkg::C_AP_RD;
			lpqm_pkg::S_AP_CHK:   cmd = lpqm_pkg::C_AP_CHK;
			lpqm_pkg::S_AP_LINK:  cmd = lpqm_pkg::C_AP_LINK;
			lpqm_pkg::S_AP_CLR:   cmd = lpqm_pkg::C_AP_CLR;
			lpqm_pkg::S_WK_BEG:   cmd = lpqm_pkg::C_WK_BEG;
			lpqm_pkg::S_WK_RD:    cmd = lpqm_pkg::C_WK_RD;
			lpqm_pkg::S_WK_CHK:   cmd = lpqm_pkg::C_WK_CHK;
			lpqm_pkg::S_WK_HRD:   cmd = lpqm_pkg::C_WK_HRD;
			lpqm_pkg::S_WK_HGET:  cmd = lpqm_pkg::C_WK_HGET;
			default:              cmd = lpqm_pkg::C_NOP;
		endcase
	end

	// a result beat is always followed by idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("result beat not followed by idle");
	// a beat is only taken while idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == lpqm_pkg::C_LOAD) |-> !busy) else $error("load while busy");
	// decode always follows an accepted beat
	a_load_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == lpqm_pkg::S_DECODE)) else $error("no decode");

endmodule

>>> rtl/core/lpqm_datapath.sv
module lpqm_datapath #(
	parameter int ENTRY_COUNT  = 64,
	parameter int CPU_COUNT    = 8,
	parameter int CHANNEL_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lpqm_pkg::cmd_t   cmd,
	input  lpqm_pkg::req_t   request,
	output lpqm_pkg::flags_t flags,
	output lpqm_pkg::rsp_t   result
);

	localparam int LW  = $clog2(ENTRY_COUNT + 1);
	localparam int IW  = $clog2(ENTRY_COUNT);
	localparam int CIW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int HN  = CPU_COUNT + 3;
	localparam int HW  = $clog2(HN);
	localparam int KW  = (CHANNEL_BITS < 16) ? CHANNEL_BITS : 16;
	localparam logic [LW-1:0] NONE = LW'(ENTRY_COUNT);

	// cpu index wrapped into range
	function automatic logic [CIW-1:0] wrap_cpu(input logic [2:0] v);
		logic [4:0] r;
		r = {2'b00, v};
		for (int i = 0; i < 8; i++) begin
			if (r >= 5'(CPU_COUNT)) r = r - 5'(CPU_COUNT);
		end
		return CIW'(r);
	endfunction

	// per-entry tables
	logic [LW-1:0]  link_mem [ENTRY_COUNT];
	logic [CIW-1:0] cpu_mem  [ENTRY_COUNT];
	logic [KW-1:0]  chan_mem [ENTRY_COUNT];
	logic [2:0]     stat_mem [ENTRY_COUNT];
	logic [IW-1:0]  hits_mem [ENTRY_COUNT];

	logic [LW-1:0]  link_rd_q;
	logic [CIW-1:0] cpu_rd_q;
	logic [KW-1:0]  chan_rd_q;
	logic [2:0]     stat_rd_q;
	logic [IW-1:0]  hit_rd_q;

	logic [LW-1:0]  head_q [HN];
	logic [ENTRY_COUNT-1:0] hit_q;
	logic [LW-1:0]  clr_q, steps_q, n_q, k_q, walk_q, woken_q;
	logic [LW-1:0]  cur_q, prev_q, t_q, e_q;
	logic           at_head_q, bad_q;
	logic [2:0]     op_q;
	logic [CIW-1:0] cpu_q;
	logic [KW-1:0]  chan_q;
	logic [1:0]     res_q;
	logic [HW-1:0]  hsel_q;

	logic [HW-1:0]  run_sel, mv_sel;
	logic [LW-1:0]  head_cur;
	logic           wk_match, wk_dup, do_entry;

	assign run_sel  = HW'(lpqm_pkg::HD_RUN0) + HW'(cpu_q);
	assign mv_sel   = HW'(lpqm_pkg::HD_RUN0) + HW'(cpu_rd_q);
	assign head_cur = head_q[hsel_q];
	assign wk_match = (chan_rd_q == chan_q);
	assign wk_dup   = hit_q[cur_q[IW-1:0]];
	assign do_entry = !bad_q;

	// status toward the controller
	always_comb begin
		flags.op         = op_q;
		flags.bad        = bad_q;
		flags.clear_last = (clr_q == LW'(ENTRY_COUNT - 1));
		flags.head_entry = (head_cur < NONE);
		flags.cmp_ok     = at_head_q || ((cur_q < NONE) && (steps_q < NONE));
		flags.cur_eq_t   = (cur_q == t_q);
		flags.res_ok     = (res_q == lpqm_pkg::RES_OK);
		flags.ap_more    = (link_rd_q < NONE) && (steps_q < NONE);
		flags.stat_sleep = (stat_rd_q == lpqm_pkg::STAT_SLEEPING);
		flags.wk_go      = (cur_q < NONE) && (n_q < NONE);
		flags.wk_stop    = (wk_match && wk_dup) || (walk_q == NONE);
		flags.k_lt_n     = (k_q < n_q);
	end

	// result beat
	always_comb begin
		result.status      = res_q;
		result.entry_out   = ((res_q == lpqm_pkg::RES_OK) &&
			(op_q == lpqm_pkg::OP_ALLOC || op_q == lpqm_pkg::OP_SCHEDULE)) ? 6'(t_q) : 6'd0;
		result.woken_count = 7'(woken_q);
	end

	// list heads, counters and hit flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HN; i++) begin
				head_q[i] <= (i == lpqm_pkg::HD_FREE) ? '0 : NONE;
			end
			hit_q   <= '0;
			clr_q   <= '0;
			steps_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			case (cmd)
				lpqm_pkg::C_CLEAR: clr_q <= clr_q + 1'b1;
				lpqm_pkg::C_RM_BEG: steps_q <= '0;
				lpqm_pkg::C_RM_NXT: begin
					if (cur_q == t_q) begin
						if (at_head_q) head_q[hsel_q] <= link_rd_q;
					end else if (!at_head_q) begin
						steps_q <= steps_q + 1'b1;
					end
				end
				lpqm_pkg::C_RM_END: begin
					if (op_q == lpqm_pkg::OP_WAKEUP) k_q <= k_q + 1'b1;
				end
				lpqm_pkg::C_AP_INIT: begin
					steps_q <= '0;
					if (!(head_cur < NONE)) head_q[hsel_q] <= t_q;
				end
				lpqm_pkg::C_AP_CHK: begin
					if ((link_rd_q < NONE) && (steps_q < NONE)) steps_q <= steps_q + 1'b1;
				end
				lpqm_pkg::C_WK_BEG: begin
					hit_q <= '0;
					n_q   <= '0;
					k_q   <= '0;
				end
				lpqm_pkg::C_WK_CHK: begin
					if (wk_match && !wk_dup) begin
						hit_q[cur_q[IW-1:0]] <= 1'b1;
						n_q <= n_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// operation and walk registers
	always_ff @(posedge clk) begin
		case (cmd)
			lpqm_pkg::C_LOAD: begin
				op_q    <= request.op;
				e_q     <= LW'(request.entry_index);
				bad_q   <= (32'(request.entry_index) >= ENTRY_COUNT);
				cpu_q   <= wrap_cpu(request.cpu_index);
				chan_q  <= KW'(request.channel);
				res_q   <= lpqm_pkg::RES_OK;
				woken_q <= '0;
				t_q     <= '0;
			end
			lpqm_pkg::C_DECODE: begin
				if (lpqm_pkg::needs_entry(op_q) && bad_q) res_q <= lpqm_pkg::RES_MISSING;
				case (op_q)
					lpqm_pkg::OP_ALLOC: begin
						hsel_q <= HW'(lpqm_pkg::HD_FREE);
						t_q    <= head_q[lpqm_pkg::HD_FREE];
					end
					lpqm_pkg::OP_SCHEDULE: begin
						hsel_q <= run_sel;
						t_q    <= head_q[run_sel];
					end
					lpqm_pkg::OP_SLEEP, lpqm_pkg::OP_KILL: begin
						hsel_q <= HW'(lpqm_pkg::HD_SLEEP);
						t_q    <= e_q;
					end
					lpqm_pkg::OP_EXIT, lpqm_pkg::OP_FREE: begin
						hsel_q <= HW'(lpqm_pkg::HD_ZOMBIE);
						t_q    <= e_q;
					end
					default: t_q <= e_q;
				endcase
			end
			lpqm_pkg::C_RM_BEG: begin
				if (!(head_cur < NONE)) res_q <= lpqm_pkg::RES_EMPTY;
				cur_q     <= head_cur;
				at_head_q <= 1'b1;
			end
			lpqm_pkg::C_RM_CMP: begin
				if (!(at_head_q || ((cur_q < NONE) && (steps_q < NONE)))) begin
					res_q <= lpqm_pkg::RES_MISSING;
				end
			end
			lpqm_pkg::C_RM_NXT: begin
				if (cur_q != t_q) begin
					prev_q    <= cur_q;
					cur_q     <= link_rd_q;
					at_head_q <= 1'b0;
				end
			end
			lpqm_pkg::C_RM_END: begin
				if (op_q == lpqm_pkg::OP_WAKEUP) begin
					res_q <= lpqm_pkg::RES_OK;
					if (res_q == lpqm_pkg::RES_OK) woken_q <= woken_q + 1'b1;
				end else if (op_q == lpqm_pkg::OP_KILL && res_q == lpqm_pkg::RES_OK) begin
					woken_q <= LW'(1);
				end else if (op_q == lpqm_pkg::OP_FREE) begin
					hsel_q <= HW'(lpqm_pkg::HD_FREE);
				end
			end
			lpqm_pkg::C_MV_SEL: hsel_q <= mv_sel;
			lpqm_pkg::C_AP_INIT: cur_q <= head_cur;
			lpqm_pkg::C_AP_CHK: begin
				if ((link_rd_q < NONE) && (steps_q < NONE)) cur_q <= link_rd_q;
			end
			lpqm_pkg::C_WK_BEG: begin
				cur_q  <= head_q[lpqm_pkg::HD_SLEEP];
				walk_q <= '0;
			end
			lpqm_pkg::C_WK_CHK: begin
				cur_q  <= link_rd_q;
				walk_q <= walk_q + 1'b1;
			end
			lpqm_pkg::C_WK_HGET: begin
				t_q    <= LW'(hit_rd_q);
				hsel_q <= HW'(lpqm_pkg::HD_SLEEP);
			end
			default: ;
		endcase
	end

	// link table
	always_ff @(posedge clk) begin
		case (cmd)
			lpqm_pkg::C_CLEAR: link_mem[clr_q[IW-1:0]] <= clr_q + 1'b1;
			lpqm_pkg::C_RM_NXT: begin
				if (cur_q == t_q && !at_head_q) link_mem[prev_q[IW-1:0]] <= link_rd_q;
			end
			lpqm_pkg::C_RM_CLR, lpqm_pkg::C_AP_INIT, lpqm_pkg::C_AP_CLR: begin
				link_mem[t_q[IW-1:0]] <= NONE;
			end
			lpqm_pkg::C_AP_LINK: link_mem[cur_q[IW-1:0]] <= t_q;
			default: ;
		endcase
		if (cmd == lpqm_pkg::C_RM_CMP || cmd == lpqm_pkg::C_AP_RD ||
			cmd == lpqm_pkg::C_WK_RD) begin
			link_rd_q <= link_mem[cur_q[IW-1:0]];
		end
	end

	// channel table
	always_ff @(posedge clk) begin
		case (cmd)
			lpqm_pkg::C_CLEAR: chan_mem[clr_q[IW-1:0]] <= '0;
			lpqm_pkg::C_DECODE: begin
				if (op_q == lpqm_pkg::OP_SLEEP && do_entry) chan_mem[e_q[IW-1:0]] <= chan_q;
			end
			lpqm_pkg::C_RM_END: begin
				if (op_q == lpqm_pkg::OP_FREE && res_q == lpqm_pkg::RES_OK) begin
					chan_mem[t_q[IW-1:0]] <= '0;
				end
			end
			default: ;
		endcase
		if (cmd == lpqm_pkg::C_WK_RD) chan_rd_q <= chan_mem[cur_q[IW-1:0]];
	end

	// status table
	always_ff @(posedge clk) begin
		case (cmd)
			lpqm_pkg::C_CLEAR: stat_mem[clr_q[IW-1:0]] <= lpqm_pkg::STAT_UNUSED;
			lpqm_pkg::C_DECODE: begin
				if (op_q == lpqm_pkg::OP_SLEEP && do_entry) begin
					stat_mem[e_q[IW-1:0]] <= lpqm_pkg::STAT_SLEEPING;
				end else if (op_q == lpqm_pkg::OP_EXIT && do_entry) begin
					stat_mem[e_q[IW-1:0]] <= lpqm_pkg::STAT_ZOMBIE;
				end
			end
			lpqm_pkg::C_RM_END: begin
				if (res_q == lpqm_pkg::RES_OK) begin
					case (op_q)
						lpqm_pkg::OP_ALLOC:    stat_mem[t_q[IW-1:0]] <= lpqm_pkg::STAT_USED;
						lpqm_pkg::OP_SCHEDULE: stat_mem[t_q[IW-1:0]] <= lpqm_pkg::STAT_RUNNING;
						lpqm_pkg::OP_FREE:     stat_mem[t_q[IW-1:0]] <= lpqm_pkg::STAT_UNUSED;
						default: ;
					endcase
				end
			end
			lpqm_pkg::C_MV_RD: stat_mem[t_q[IW-1:0]] <= lpqm_pkg::STAT_RUNNABLE;
			default: ;
		endcase
		if (cmd == lpqm_pkg::C_DECODE) stat_rd_q <= stat_mem[e_q[IW-1:0]];
	end

	// cpu table
	always_ff @(posedge clk) begin
		case (cmd)
			lpqm_pkg::C_CLEAR: cpu_mem[clr_q[IW-1:0]] <= '0;
			lpqm_pkg::C_DECODE: begin
				if (op_q == lpqm_pkg::OP_MAKE_RUN && do_entry) cpu_mem[e_q[IW-1:0]] <= cpu_q;
			end
			default: ;
		endcase
		if (cmd == lpqm_pkg::C_MV_RD) cpu_rd_q <= cpu_mem[t_q[IW-1:0]];
	end

	// wakeup hit list
	always_ff @(posedge clk) begin
		if (cmd == lpqm_pkg::C_WK_CHK && wk_match && !wk_dup) begin
			hits_mem[n_q[IW-1:0]] <= cur_q[IW-1:0];
		end
		if (cmd == lpqm_pkg::C_WK_HRD) hit_rd_q <= hits_mem[k_q[IW-1:0]];
	end

	// walk bounds
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= NONE) else $error("walk step count past table size");
	a_hits: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= n_q) else $error("hit replay past hit count");
	a_link_cur: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == lpqm_pkg::C_AP_LINK) |-> (cur_q < NONE)) else $error("append tail not an entry");

endmodule

>>> verif/tb.sv
module tb;

	localparam int ENTRIES  = 64;
	localparam int CPUS     = 8;
	localparam int NO_LINK  = ENTRIES;
	localparam int N_RANDOM = 700;

	// head slots follow the package layout
	localparam int N_HEADS = lpqm_pkg::HD_RUN0 + CPUS;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	lpqm_pkg::req_t request;
	logic done;
	lpqm_pkg::rsp_t result;

	linked_process_queue_manager_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// shadow task table
	int         nxt_link [ENTRIES];
	logic [2:0] ent_cpu [ENTRIES];
	logic [15:0] ent_chan [ENTRIES];
	logic [2:0] ent_stat [ENTRIES];
	logic       ent_killed [ENTRIES];
	int         heads [N_HEADS];

	lpqm_pkg::rsp_t pending_rsp [$];
	int   n_fail;

	// directed rows: typed expectation only where has_rsp is set
	typedef struct {
		lpqm_pkg::req_t rq;
		bit   has_rsp;
		lpqm_pkg::rsp_t rsp;
	} row_t;

	function automatic lpqm_pkg::req_t mk_req(logic [2:0] op, int ent, int cpu, int chn);
		lpqm_pkg::req_t r;
		r.op = op;
		r.entry_index = ent[5:0];
		r.cpu_index = cpu[2:0];
		r.channel = chn[15:0];
		return r;
	endfunction

	function automatic lpqm_pkg::rsp_t mk_rsp(logic [1:0] st, int ent, int cnt);
		lpqm_pkg::rsp_t r;
		r.status = st;
		r.entry_out = ent[5:0];
		r.woken_count = cnt[6:0];
		return r;
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < ENTRIES; i++) begin
			nxt_link[i] = i + 1;
			ent_cpu[i] = '0;
			ent_chan[i] = '0;
			ent_stat[i] = lpqm_pkg::STAT_UNUSED;
			ent_killed[i] = 1'b0;
		end
		heads[lpqm_pkg::HD_FREE] = 0;
		for (int h = lpqm_pkg::HD_SLEEP; h < N_HEADS; h++)
			heads[h] = NO_LINK;
	endfunction

	// tail append, walk bounded by table size
	function automatic void tail_link(int hs, int e);
		int cur;
		int steps;
		cur = heads[hs];
		steps = 0;
		nxt_link[e] = NO_LINK;
		if (cur >= ENTRIES) begin
			heads[hs] = e;
			return;
		end
		while (nxt_link[cur] < ENTRIES && steps < ENTRIES) begin
			cur = nxt_link[cur];
			steps++;
		end
		nxt_link[cur] = e;
		nxt_link[e] = NO_LINK;
	endfunction

	function automatic logic [1:0] unlink(int hs, int e);
		int prv;
		int cur;
		int steps;
		steps = 0;
		if (heads[hs] >= ENTRIES)
			return lpqm_pkg::RES_EMPTY;
		if (heads[hs] == e) begin
			heads[hs] = nxt_link[e];
			nxt_link[e] = NO_LINK;
			return lpqm_pkg::RES_OK;
		end
		prv = heads[hs];
		cur = nxt_link[prv];
		while (cur < ENTRIES && steps < ENTRIES) begin
			if (cur == e) begin
				nxt_link[prv] = nxt_link[e];
				nxt_link[e] = NO_LINK;
				return lpqm_pkg::RES_OK;
			end
			prv = cur;
			cur = nxt_link[cur];
			steps++;
		end
		return lpqm_pkg::RES_MISSING;
	endfunction

	function automatic void to_run_list(int e);
		ent_stat[e] = lpqm_pkg::STAT_RUNNABLE;
		tail_link(lpqm_pkg::HD_RUN0 + (int'(ent_cpu[e]) % CPUS), e);
	endfunction

	// apply one command to the shadow table and return its response
	function automatic lpqm_pkg::rsp_t queue_op(lpqm_pkg::req_t r);
		logic [1:0] st;
		int got;
		int woken;
		int e;
		int cpu;
		int hits [ENTRIES];
		int n;
		int cur;
		int nx;
		bit dup;
		lpqm_pkg::rsp_t o;
		st = lpqm_pkg::RES_OK;
		got = 0;
		woken = 0;
		e = int'(r.entry_index);
		cpu = int'(r.cpu_index) % CPUS;
		case (r.op)
			lpqm_pkg::OP_ALLOC, lpqm_pkg::OP_SCHEDULE: begin
				int hs;
				hs = (r.op == lpqm_pkg::OP_ALLOC) ? lpqm_pkg::HD_FREE
					: lpqm_pkg::HD_RUN0 + cpu;
				if (heads[hs] >= ENTRIES) begin
					st = lpqm_pkg::RES_EMPTY;
				end else begin
					got = heads[hs];
					heads[hs] = nxt_link[got];
					nxt_link[got] = NO_LINK;
					ent_stat[got] = (r.op == lpqm_pkg::OP_ALLOC) ? lpqm_pkg::STAT_USED
						: lpqm_pkg::STAT_RUNNING;
				end
			end
			lpqm_pkg::OP_MAKE_RUN: begin
				ent_cpu[e] = cpu[2:0];
				to_run_list(e);
			end
			lpqm_pkg::OP_SLEEP: begin
				ent_chan[e] = r.channel;
				ent_stat[e] = lpqm_pkg::STAT_SLEEPING;
				tail_link(lpqm_pkg::HD_SLEEP, e);
			end
			lpqm_pkg::OP_WAKEUP: begin
				// collect matches first, stop on a repeated hit or a runaway walk
				n = 0;
				cur = heads[lpqm_pkg::HD_SLEEP];
				while (cur < ENTRIES && n < ENTRIES) begin
					nx = nxt_link[cur];
					if (ent_chan[cur] == r.channel) begin
						dup = 0;
						for (int k = 0; k < n; k++)
							if (hits[k] == cur)
								dup = 1;
						if (dup)
							break;
						hits[n] = cur;
						n++;
					end
					cur = nx;
					woken++;
					if (woken > ENTRIES)
						break;
				end
				woken = 0;
				for (int k = 0; k < n; k++) begin
					if (unlink(lpqm_pkg::HD_SLEEP, hits[k]) == lpqm_pkg::RES_OK) begin
						to_run_list(hits[k]);
						woken++;
					end
				end
			end
			lpqm_pkg::OP_EXIT: begin
				ent_stat[e] = lpqm_pkg::STAT_ZOMBIE;
				tail_link(lpqm_pkg::HD_ZOMBIE, e);
			end
			lpqm_pkg::OP_FREE: begin
				st = unlink(lpqm_pkg::HD_ZOMBIE, e);
				if (st == lpqm_pkg::RES_OK) begin
					ent_chan[e] = '0;
					ent_killed[e] = 1'b0;
					ent_stat[e] = lpqm_pkg::STAT_UNUSED;
					tail_link(lpqm_pkg::HD_FREE, e);
				end
			end
			default: begin
				ent_killed[e] = 1'b1;
				if (ent_stat[e] == lpqm_pkg::STAT_SLEEPING) begin
					st = unlink(lpqm_pkg::HD_SLEEP, e);
					if (st == lpqm_pkg::RES_OK) begin
						to_run_list(e);
						woken = 1;
					end
				end
			end
		endcase
		o.status = st;
		o.entry_out = (st == lpqm_pkg::RES_OK) ? got[5:0] : 6'd0;
		o.woken_count = woken[6:0];
		return o;
	endfunction

	// result checker, one beat per done cycle
	always @(posedge clk) begin
		lpqm_pkg::rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$error("unexpected result beat %p", result);
				n_fail++;
			end else begin
				want = pending_rsp.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, result.status);
					n_fail++;
				end
				if (result.entry_out !== want.entry_out) begin
					$error("entry_out: expected %0d actual %0d",
						want.entry_out, result.entry_out);
					n_fail++;
				end
				if (result.woken_count !== want.woken_count) begin
					$error("woken_count: expected %0d actual %0d",
						want.woken_count, result.woken_count);
					n_fail++;
				end
			end
		end
	end

	bit  no_idle;

	function automatic int pick_gap();
		int p;
		if (no_idle)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// issue one command beat and update the prediction on acceptance
	task automatic issue(lpqm_pkg::req_t r, bit has_rsp, lpqm_pkg::rsp_t typed);
		int gap;
		lpqm_pkg::rsp_t calc;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		calc = queue_op(r);
		pending_rsp.push_back(has_rsp ? typed : calc);
	endtask

	function automatic lpqm_pkg::req_t rand_cmd();
		lpqm_pkg::req_t r;
		int p;
		p = $urandom_range(0, 99);
		if (p < 18)      r.op = lpqm_pkg::OP_ALLOC;
		else if (p < 33) r.op = lpqm_pkg::OP_MAKE_RUN;
		else if (p < 48) r.op = lpqm_pkg::OP_SCHEDULE;
		else if (p < 63) r.op = lpqm_pkg::OP_SLEEP;
		else if (p < 72) r.op = lpqm_pkg::OP_WAKEUP;
		else if (p < 82) r.op = lpqm_pkg::OP_EXIT;
		else if (p < 92) r.op = lpqm_pkg::OP_FREE;
		else             r.op = lpqm_pkg::OP_KILL;
		// most traffic on low entries, which alloc hands out first
		r.entry_index = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, 15))
			: 6'($urandom_range(0, ENTRIES - 1));
		r.cpu_index = 3'($urandom_range(0, 7));
		p = $urandom_range(0, 99);
		if (p < 80)      r.channel = 16'($urandom_range(0, 3));
		else if (p < 88) r.channel = 16'hffff;
		else             r.channel = 16'($urandom_range(0, 16'hffff));
		return r;
	endfunction

	row_t rows [$];
	lpqm_pkg::rsp_t none_rsp;

	initial begin
		n_fail = 0;
		no_idle = 0;
		start = 1'b0;
		request = '0;
		arst_n = 1'b0;
		none_rsp = '0;
		table_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty lists, extremes, not found, kill paths, wakeup
		rows.push_back('{mk_req(lpqm_pkg::OP_SCHEDULE, 0, 0, 0), 1,
			mk_rsp(lpqm_pkg::RES_EMPTY, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_WAKEUP, 0, 7, 0), 1,
			mk_rsp(lpqm_pkg::RES_OK, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_FREE, 63, 0, 0), 1,
			mk_rsp(lpqm_pkg::RES_EMPTY, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_KILL, 5, 0, 0), 1,
			mk_rsp(lpqm_pkg::RES_OK, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_ALLOC, 0, 0, 0), 1,
			mk_rsp(lpqm_pkg::RES_OK, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_ALLOC, 63, 7, 16'hffff), 1,
			mk_rsp(lpqm_pkg::RES_OK, 1, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_EXIT, 0, 0, 0), 1,
			mk_rsp(lpqm_pkg::RES_OK, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_FREE, 1, 0, 0), 1,
			mk_rsp(lpqm_pkg::RES_MISSING, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_FREE, 0, 0, 0), 1,
			mk_rsp(lpqm_pkg::RES_OK, 0, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_MAKE_RUN, 1, 7, 0), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_SCHEDULE, 0, 7, 0), 1,
			mk_rsp(lpqm_pkg::RES_OK, 1, 0)});
		rows.push_back('{mk_req(lpqm_pkg::OP_SLEEP, 2, 3, 16'hffff), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_SLEEP, 63, 0, 16'hffff), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_SLEEP, 3, 0, 16'h0001), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_WAKEUP, 0, 0, 16'hffff), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_KILL, 3, 0, 0), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_SLEEP, 4, 0, 16'h0007), 0, none_rsp});
		// sleeping mark but unlinked: make-run on 4 cuts list after 4, then re-sleep and kill 4
		rows.push_back('{mk_req(lpqm_pkg::OP_SLEEP, 5, 0, 16'h0007), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_ALLOC, 0, 0, 0), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_MAKE_RUN, 4, 2, 0), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_SLEEP, 4, 2, 16'h0007), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_MAKE_RUN, 5, 2, 0), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_KILL, 4, 0, 0), 0, none_rsp});
		rows.push_back('{mk_req(lpqm_pkg::OP_SCHEDULE, 0, 2, 0), 0, none_rsp});
		foreach (rows[i])
			issue(rows[i].rq, rows[i].has_rsp, rows[i].rsp);

		// random traffic, alternating idle and back-to-back stretches
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 60 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			issue(rand_cmd(), 0, none_rsp);
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#1000000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
